// ----- rtl/core/ppj_pkg.sv -----
`default_nettype none

package ppj_pkg;

    localparam int QN         = 24;
    localparam int ADDR_W     = 6;
    localparam int MUL_LAT    = 3;
    localparam int CAM_LAT    = 2;
    localparam int DIV_STAGES = 28;
    localparam int DIV_LAT    = DIV_STAGES + 2;
    localparam int DIST_LAT   = 5 * MUL_LAT + 3;
    localparam int QUOT_W     = 56;

    localparam logic signed [63:0] LIM60 = 64'sh0FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] LIM32 = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] ONE_Q = 64'sd16777216;

    typedef enum logic [2:0] {
        REG_ROT0,
        REG_ROT1,
        REG_ROT2,
        REG_TRANS_XY,
        REG_TRANS_Z,
        REG_FOCAL_SKEW,
        REG_PP_K3,
        REG_DIST
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [31:0] pixel_u;
        logic signed [31:0] pixel_v;
        logic signed [31:0] camera_depth;
        logic               depth_zero;
        logic               saturated;
    } result_t;

    typedef struct packed {
        logic signed [15:0] k1;
        logic signed [15:0] k2;
        logic signed [15:0] k3;
        logic signed [15:0] p1;
        logic signed [15:0] p2;
    } dist_coef_t;

    typedef struct packed {
        logic signed [63:0] val;
        logic               sat;
    } clamp_t;

    typedef struct packed {
        logic [31:0]       rem;
        logic [QUOT_W-1:0] work;
    } div_state_t;

    function automatic clamp_t clamp_lim(input logic signed [63:0] v,
                                         input logic signed [63:0] lim);
        clamp_t r;
        r.val = v;
        r.sat = 1'b0;
        if (v > lim)
        begin
            r.val = lim;
            r.sat = 1'b1;
        end
        else if (v < -lim - 64'sd1)
        begin
            r.val = -lim - 64'sd1;
            r.sat = 1'b1;
        end
        return r;
    endfunction

    // one restoring step: next dividend bit into remainder, quotient bit out
    function automatic div_state_t div_step(input div_state_t s, input logic [31:0] den);
        logic [32:0] trial;
        div_state_t  r;
        trial  = {s.rem, s.work[QUOT_W-1]};
        r.work = {s.work[QUOT_W-2:0], 1'b0};
        if (trial >= {1'b0, den})
        begin
            r.rem     = 32'(trial - {1'b0, den});
            r.work[0] = 1'b1;
        end
        else
        begin
            r.rem = trial[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ppj_delay.sv -----
`default_nettype none

module ppj_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

`default_nettype wire

// ----- rtl/core/ppj_mulsh.sv -----
`default_nettype none

// signed multiply, round half away from zero at SHIFT, clamp to 60-bit magnitude
module ppj_mulsh
    import ppj_pkg::*;
#(
    parameter int SHIFT = 24
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [63:0] a,
    input  wire logic signed [63:0] b,
    output logic signed      [63:0] p,
    output logic                    sat
);

    localparam int HW = 31;
    localparam int PW = 4 * HW;

    logic [63:0]      a_mag;
    logic [63:0]      b_mag;
    logic [2*HW-1:0]  ll_reg;
    logic [2*HW-1:0]  lh_reg;
    logic [2*HW-1:0]  hl_reg;
    logic [2*HW-1:0]  hh_reg;
    logic             neg1_reg;
    logic             neg2_reg;
    logic [PW-1:0]    prod_reg;
    logic [PW:0]      rnd;
    logic [PW:0]      shifted;
    logic             over;
    logic signed [63:0] mag_res;
    logic signed [63:0] p_reg;
    logic             sat_reg;

    assign a_mag = a[63] ? (~a + 64'd1) : a;
    assign b_mag = b[63] ? (~b + 64'd1) : b;

    always_comb
    begin
        rnd     = (PW+1)'(prod_reg) + ((PW+1)'(1) << (SHIFT - 1));
        shifted = rnd >> SHIFT;
        over    = shifted > (PW+1)'(LIM60);
        mag_res = over ? LIM60 : 64'(shifted);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg   <= a_mag[HW-1:0] * b_mag[HW-1:0];
            lh_reg   <= a_mag[HW-1:0] * b_mag[2*HW-1:HW];
            hl_reg   <= a_mag[2*HW-1:HW] * b_mag[HW-1:0];
            hh_reg   <= a_mag[2*HW-1:HW] * b_mag[2*HW-1:HW];
            neg1_reg <= a[63] ^ b[63];
            prod_reg <= PW'(ll_reg) + ((PW'(lh_reg) + PW'(hl_reg)) << HW)
                        + (PW'(hh_reg) << (2 * HW));
            neg2_reg <= neg1_reg;
            p_reg    <= neg2_reg ? -mag_res : mag_res;
            sat_reg  <= over;
        end
    end

    assign p   = p_reg;
    assign sat = sat_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ppj_div.sv -----
`default_nettype none

// pipelined radix-4 restoring divide: round(|num| * 2^24 / |den|), signed result
module ppj_div
    import ppj_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [31:0] num,
    input  wire logic signed [31:0] den,
    output logic signed      [63:0] quot
);

    logic [31:0]        num_mag;
    logic [31:0]        den_mag;
    div_state_t         st_reg  [DIV_STAGES+1];
    logic [31:0]        den_reg [DIV_STAGES+1];
    logic               neg_reg [DIV_STAGES+1];
    logic signed [63:0] q_ext;
    logic signed [63:0] quot_reg;

    assign num_mag = num[31] ? (~num + 32'd1) : num;
    assign den_mag = den[31] ? (~den + 32'd1) : den;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0].rem  <= '0;
            st_reg[0].work <= {num_mag, 24'b0} + QUOT_W'(den_mag >> 1);
            den_reg[0]     <= den_mag;
            neg_reg[0]     <= num[31] ^ den[31];
        end
    end

    for (genvar g = 1; g <= DIV_STAGES; g++)
    begin : g_stage
        div_state_t s_a;
        div_state_t s_b;

        always_comb
        begin
            s_a = div_step(st_reg[g-1], den_reg[g-1]);
            s_b = div_step(s_a, den_reg[g-1]);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[g]  <= s_b;
                den_reg[g] <= den_reg[g-1];
                neg_reg[g] <= neg_reg[g-1];
            end
        end
    end

    assign q_ext = {8'b0, st_reg[DIV_STAGES].work};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg <= neg_reg[DIV_STAGES] ? -q_ext : q_ext;
        end
    end

    assign quot = quot_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ppj_cam.sv -----
`default_nettype none

// world to camera frame: R*p rounded to Q16.16, plus t, clamped to 32 bits
module ppj_cam
    import ppj_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   en,
    input  wire point_t                 pt,
    input  wire logic [2:0][59:0]       rot,
    input  wire logic [2:0][31:0]       trans,
    output logic signed [31:0]          cam_x,
    output logic signed [31:0]          cam_y,
    output logic signed [31:0]          cam_z,
    output logic                        sat
);

    logic signed [19:0] rot_e    [3][3];
    logic signed [31:0] pnt      [3];
    logic signed [51:0] prod_reg [3][3];
    logic signed [53:0] acc      [3];
    logic signed [63:0] sum      [3];
    clamp_t             cl       [3];
    logic signed [31:0] axis_reg [3];
    logic               sat_reg;

    always_comb
    begin
        pnt[0] = pt.point_x;
        pnt[1] = pt.point_y;
        pnt[2] = pt.point_z;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                rot_e[i][j] = rot[i][20*j +: 20];
            end
            acc[i] = 54'(prod_reg[i][0]) + 54'(prod_reg[i][1]) + 54'(prod_reg[i][2])
                     + 54'sd131072;
            sum[i] = 64'(acc[i] >>> 18) + 64'($signed(trans[i]));
            cl[i]  = clamp_lim(sum[i], LIM32);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[i][j] <= rot_e[i][j] * pnt[j];
                end
                axis_reg[i] <= cl[i].val[31:0];
            end
            sat_reg <= cl[0].sat | cl[1].sat | cl[2].sat;
        end
    end

    assign cam_x = axis_reg[0];
    assign cam_y = axis_reg[1];
    assign cam_z = axis_reg[2];
    assign sat   = sat_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ppj_dist.sv -----
`default_nettype none

// Brown-Conrady radial and tangential distortion on Q.24 normalized coordinates
module ppj_dist
    import ppj_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [63:0] x,
    input  wire logic signed [63:0] y,
    input  wire dist_coef_t         coef,
    output logic signed      [63:0] xd,
    output logic signed      [63:0] yd,
    output logic                    sat
);

    logic dist_on;

    logic signed [63:0] xx, yy, xy;
    logic               xx_sat, yy_sat, xy_sat;
    logic signed [63:0] x14, y14, x17, y17;
    clamp_t             r2c;
    logic signed [63:0] r2_reg, xx4_reg, yy4_reg, xy4_reg;
    logic               s4_reg;
    clamp_t             txc, tyc;
    logic signed [63:0] tx14, ty14, xy14;
    logic signed [63:0] r4, r2_7, r2_10, r4_10, r6;
    logic               r4_sat, r6_sat;
    logic               s7, s10, s13, s17;
    logic signed [63:0] kr1, kr2, kr3;
    logic               kr1_sat, kr2_sat, kr3_sat;
    clamp_t             radc;
    logic signed [63:0] radial_reg;
    logic               s14_reg;
    logic signed [63:0] mxr, mxp1, mxp2, myr, myp1, myp2;
    logic               mxr_s, mxp1_s, mxp2_s, myr_s, myp1_s, myp2_s;
    clamp_t             xdc, ydc;
    logic signed [63:0] xd_reg, yd_reg;
    logic               sat_reg;

    assign dist_on = |{coef.k1, coef.k2, coef.k3, coef.p1, coef.p2};

    // squares and cross term
    ppj_mulsh #(.SHIFT(QN)) u_xx (.clk, .en, .a(x), .b(x), .p(xx), .sat(xx_sat));
    ppj_mulsh #(.SHIFT(QN)) u_yy (.clk, .en, .a(y), .b(y), .p(yy), .sat(yy_sat));
    ppj_mulsh #(.SHIFT(QN)) u_xy (.clk, .en, .a(x), .b(y), .p(xy), .sat(xy_sat));

    ppj_delay #(.WIDTH(128), .DEPTH(4 * MUL_LAT + 2)) u_xy_d14 (
        .clk, .en, .din({x, y}), .dout({x14, y14})
    );
    ppj_delay #(.WIDTH(128), .DEPTH(MUL_LAT)) u_xy_d17 (
        .clk, .en, .din({x14, y14}), .dout({x17, y17})
    );

    // r2
    assign r2c = clamp_lim(xx + yy, LIM60);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r2_reg  <= r2c.val;
            xx4_reg <= xx;
            yy4_reg <= yy;
            xy4_reg <= xy;
            s4_reg  <= xx_sat | yy_sat | xy_sat | r2c.sat;
        end
    end

    // tangential arguments, r4
    assign txc = clamp_lim(r2_reg + (xx4_reg <<< 1), LIM60);
    assign tyc = clamp_lim(r2_reg + (yy4_reg <<< 1), LIM60);

    ppj_delay #(.WIDTH(192), .DEPTH(3 * MUL_LAT + 1)) u_t_d14 (
        .clk, .en, .din({txc.val, tyc.val, xy4_reg}), .dout({tx14, ty14, xy14})
    );

    ppj_mulsh #(.SHIFT(QN)) u_r4 (.clk, .en, .a(r2_reg), .b(r2_reg), .p(r4), .sat(r4_sat));

    ppj_delay #(.WIDTH(65), .DEPTH(MUL_LAT)) u_d7 (
        .clk, .en, .din({r2_reg, s4_reg | txc.sat | tyc.sat}), .dout({r2_7, s7})
    );

    // r6
    ppj_mulsh #(.SHIFT(QN)) u_r6 (.clk, .en, .a(r4), .b(r2_7), .p(r6), .sat(r6_sat));

    ppj_delay #(.WIDTH(129), .DEPTH(MUL_LAT)) u_d10 (
        .clk, .en, .din({r2_7, r4, s7 | r4_sat}), .dout({r2_10, r4_10, s10})
    );

    // radial polynomial
    ppj_mulsh #(.SHIFT(12)) u_k1 (
        .clk, .en, .a(64'(coef.k1)), .b(r2_10), .p(kr1), .sat(kr1_sat)
    );
    ppj_mulsh #(.SHIFT(12)) u_k2 (
        .clk, .en, .a(64'(coef.k2)), .b(r4_10), .p(kr2), .sat(kr2_sat)
    );
    ppj_mulsh #(.SHIFT(12)) u_k3 (
        .clk, .en, .a(64'(coef.k3)), .b(r6), .p(kr3), .sat(kr3_sat)
    );

    ppj_delay #(.WIDTH(1), .DEPTH(MUL_LAT)) u_d13 (
        .clk, .en, .din(s10 | r6_sat), .dout(s13)
    );

    assign radc = clamp_lim(ONE_Q + kr1 + kr2 + kr3, LIM60);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            radial_reg <= radc.val;
            s14_reg    <= s13 | kr1_sat | kr2_sat | kr3_sat | radc.sat;
        end
    end

    // distorted point
    ppj_mulsh #(.SHIFT(QN)) u_mxr (
        .clk, .en, .a(x14), .b(radial_reg), .p(mxr), .sat(mxr_s)
    );
    ppj_mulsh #(.SHIFT(11)) u_mxp1 (
        .clk, .en, .a(64'(coef.p1)), .b(xy14), .p(mxp1), .sat(mxp1_s)
    );
    ppj_mulsh #(.SHIFT(12)) u_mxp2 (
        .clk, .en, .a(64'(coef.p2)), .b(tx14), .p(mxp2), .sat(mxp2_s)
    );
    ppj_mulsh #(.SHIFT(QN)) u_myr (
        .clk, .en, .a(y14), .b(radial_reg), .p(myr), .sat(myr_s)
    );
    ppj_mulsh #(.SHIFT(12)) u_myp1 (
        .clk, .en, .a(64'(coef.p1)), .b(ty14), .p(myp1), .sat(myp1_s)
    );
    ppj_mulsh #(.SHIFT(11)) u_myp2 (
        .clk, .en, .a(64'(coef.p2)), .b(xy14), .p(myp2), .sat(myp2_s)
    );

    ppj_delay #(.WIDTH(1), .DEPTH(MUL_LAT)) u_d17 (
        .clk, .en, .din(s14_reg), .dout(s17)
    );

    assign xdc = clamp_lim(mxr + mxp1 + mxp2, LIM60);
    assign ydc = clamp_lim(myr + myp1 + myp2, LIM60);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xd_reg  <= dist_on ? xdc.val : x17;
            yd_reg  <= dist_on ? ydc.val : y17;
            sat_reg <= dist_on & (s17 | mxr_s | mxp1_s | mxp2_s | myr_s | myp1_s | myp2_s
                                  | xdc.sat | ydc.sat);
        end
    end

    assign xd  = xd_reg;
    assign yd  = yd_reg;
    assign sat = sat_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pinhole_projection_with_distortion.sv -----
`default_nettype none

// Pinhole projection with Brown-Conrady distortion. Takes one point per cycle
// while the result side does not stall, and returns each result in order after
// it passes through rotation and translation, the pair of radix-4 dividers (28
// stages of two quotient bits each for the 56-bit quotient), the distortion
// chain (five dependent 3-stage multiply-round units plus three add/clamp
// stages), and the intrinsics. A stall while a result is valid freezes the
// whole pipeline at once, so the point channel stalls in the same cycle.
// Registers are written over APB at byte address 8*index, 64-bit data.
module pinhole_projection_with_distortion
    import ppj_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              point_valid,
    output logic                   point_stall,
    input  wire point_t            point,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output result_t                result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [63:0]       pwdata,
    output logic [63:0]            prdata,
    output logic                   pready
);

    localparam int SIDE_LAT = DIV_LAT + DIST_LAT + MUL_LAT;
    localparam int LAT      = CAM_LAT + SIDE_LAT + 1;

    logic [59:0]        rot_reg [3];
    logic [63:0]        trans_xy_reg;
    logic [31:0]        trans_z_reg;
    logic [63:0]        focal_reg;
    logic [63:0]        pp_reg;
    logic [63:0]        dist_reg;

    logic               wr;
    reg_idx_t           idx;
    logic               adv;
    logic [LAT-1:0]     vld_reg;

    logic signed [31:0] cam_x, cam_y, cam_z;
    logic               cam_sat;
    logic signed [63:0] nx, ny;
    dist_coef_t         coef;
    logic signed [63:0] xd, yd;
    logic               dist_sat, dist_sat_d;
    logic signed [31:0] cz_d;
    logic               cam_sat_d;
    logic signed [63:0] mu, ms, mv;
    logic               mu_sat, ms_sat, mv_sat;
    logic signed [63:0] fx, fy, skew, ccx, ccy;
    clamp_t             uc, vc;
    logic               dz;
    result_t            result_next;
    result_t            result_reg;

    // config port
    assign wr     = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[5:3]);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg[0]   <= 60'd262144;
            rot_reg[1]   <= 60'd274877906944;
            rot_reg[2]   <= 60'd288230376151711744;
            trans_xy_reg <= '0;
            trans_z_reg  <= '0;
            focal_reg    <= 64'd4294967552;
            pp_reg       <= '0;
            dist_reg     <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_ROT0:       rot_reg[0]   <= pwdata[59:0];
                REG_ROT1:       rot_reg[1]   <= pwdata[59:0];
                REG_ROT2:       rot_reg[2]   <= pwdata[59:0];
                REG_TRANS_XY:   trans_xy_reg <= pwdata;
                REG_TRANS_Z:    trans_z_reg  <= pwdata[31:0];
                REG_FOCAL_SKEW: focal_reg    <= pwdata;
                REG_PP_K3:      pp_reg       <= pwdata;
                REG_DIST:       dist_reg     <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ROT0:       prdata = {4'b0, rot_reg[0]};
            REG_ROT1:       prdata = {4'b0, rot_reg[1]};
            REG_ROT2:       prdata = {4'b0, rot_reg[2]};
            REG_TRANS_XY:   prdata = trans_xy_reg;
            REG_TRANS_Z:    prdata = {32'b0, trans_z_reg};
            REG_FOCAL_SKEW: prdata = focal_reg;
            REG_PP_K3:      prdata = pp_reg;
            REG_DIST:       prdata = dist_reg;
        endcase
    end

    // pipeline control
    assign adv         = !(vld_reg[LAT-1] && result_stall);
    assign point_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], point_valid};
        end
    end

    // camera frame
    ppj_cam u_cam (
        .clk,
        .en    (adv),
        .pt    (point),
        .rot   ({rot_reg[2], rot_reg[1], rot_reg[0]}),
        .trans ({trans_z_reg, trans_xy_reg[63:32], trans_xy_reg[31:0]}),
        .cam_x (cam_x),
        .cam_y (cam_y),
        .cam_z (cam_z),
        .sat   (cam_sat)
    );

    // normalize by depth
    ppj_div u_div_x (.clk, .en(adv), .num(cam_x), .den(cam_z), .quot(nx));
    ppj_div u_div_y (.clk, .en(adv), .num(cam_y), .den(cam_z), .quot(ny));

    ppj_delay #(.WIDTH(33), .DEPTH(SIDE_LAT)) u_side_d (
        .clk, .en(adv), .din({cam_z, cam_sat}), .dout({cz_d, cam_sat_d})
    );

    // lens distortion
    assign coef.k1 = dist_reg[15:0];
    assign coef.k2 = dist_reg[31:16];
    assign coef.p1 = dist_reg[47:32];
    assign coef.p2 = dist_reg[63:48];
    assign coef.k3 = pp_reg[63:48];

    ppj_dist u_dist (
        .clk, .en(adv), .x(nx), .y(ny), .coef(coef), .xd(xd), .yd(yd), .sat(dist_sat)
    );

    ppj_delay #(.WIDTH(1), .DEPTH(MUL_LAT)) u_dsat_d (
        .clk, .en(adv), .din(dist_sat), .dout(dist_sat_d)
    );

    // intrinsics
    assign fx   = {40'b0, focal_reg[23:0]};
    assign fy   = {40'b0, focal_reg[47:24]};
    assign skew = 64'($signed(focal_reg[63:48]));
    assign ccx  = {40'b0, pp_reg[23:0]};
    assign ccy  = {40'b0, pp_reg[47:24]};

    ppj_mulsh #(.SHIFT(QN)) u_fx (.clk, .en(adv), .a(fx), .b(xd), .p(mu), .sat(mu_sat));
    ppj_mulsh #(.SHIFT(QN)) u_sk (.clk, .en(adv), .a(skew), .b(yd), .p(ms), .sat(ms_sat));
    ppj_mulsh #(.SHIFT(QN)) u_fy (.clk, .en(adv), .a(fy), .b(yd), .p(mv), .sat(mv_sat));

    always_comb
    begin
        uc = clamp_lim(mu + ms + ccx, LIM32);
        vc = clamp_lim(mv + ccy, LIM32);
        dz = (cz_d == 32'sd0);
        result_next.pixel_u      = dz ? '0 : uc.val[31:0];
        result_next.pixel_v      = dz ? '0 : vc.val[31:0];
        result_next.camera_depth = cz_d;
        result_next.depth_zero   = dz;
        result_next.saturated    = cam_sat_d
                                   | (!dz & (dist_sat_d | mu_sat | ms_sat | mv_sat
                                             | uc.sat | vc.sat));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = vld_reg[LAT-1];

endmodule

`default_nettype wire

// ----- rtl/core/ppj_checker.sv -----
`default_nettype none

module ppj_checker
    import ppj_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              point_stall,
    input wire logic              result_valid,
    input wire logic              result_stall,
    input wire result_t           result
);

    // stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed under stall");

    // input side stalls exactly when the output register is blocked
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        point_stall == (result_valid && result_stall))
        else $error("point stall does not follow result stall");

    a_dz_pix: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.depth_zero |-> result.pixel_u == 32'sd0
                                             && result.pixel_v == 32'sd0)
        else $error("nonzero pixels on zero depth");

    a_dz_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.depth_zero == (result.camera_depth == 32'sd0))
        else $error("depth flag disagrees with depth");

endmodule

bind pinhole_projection_with_distortion ppj_checker u_ppj_checker (.*);

`default_nettype wire

// ----- bench/pinhole_projection_with_distortion_tb.sv -----
`default_nettype none

module pinhole_projection_with_distortion_tb;
    import ppj_pkg::*;

    localparam longint LIM_I = 64'sh0FFF_FFFF_FFFF_FFFF;
    localparam longint MAX32 = 64'sh0000_0000_7FFF_FFFF;
    localparam int PIPE_LAT = 54;
    localparam int CYCLE_LIMIT = 400000;

    logic              clk;
    logic              rst_n;
    logic              point_valid;
    logic              point_stall;
    point_t            point;
    logic              result_valid;
    logic              result_stall;
    result_t           result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [63:0]       pwdata;
    logic [63:0]       prdata;
    logic              pready;

    pinhole_projection_with_distortion dut (
        .clk(clk), .rst_n(rst_n),
        .point_valid(point_valid), .point_stall(point_stall), .point(point),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    logic [63:0] cam_regs [8];
    result_t     pending_results [$];
    int          errors;
    int          cycles;
    bit          hold_long;

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic longint sx(input logic [63:0] v, input int w);
        logic [63:0] m;
        m = 64'd1 << (w - 1);
        v = v & ((m << 1) - 64'd1);
        return longint'(v ^ m) - longint'(m);
    endfunction

    function automatic longint clip(input longint v, input longint lim, inout bit sat);
        if (v > lim)
        begin
            sat = 1'b1;
            return lim;
        end
        if (v < -lim - 1)
        begin
            sat = 1'b1;
            return -lim - 1;
        end
        return v;
    endfunction

    function automatic logic [63:0] absval(input longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function automatic longint mul_round(input longint a, input longint b, input int s,
                                         inout bit sat);
        logic [127:0] p;
        logic [127:0] r;
        bit           neg;
        neg = (a < 0) != (b < 0);
        p = 128'(absval(a)) * 128'(absval(b));
        r = (p + (128'd1 << (s - 1))) >> s;
        if (r > 128'(LIM_I))
        begin
            sat = 1'b1;
            r = 128'(LIM_I);
        end
        return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
    endfunction

    function automatic longint cam_axis(input logic [63:0] row, input longint px,
                                        input longint py, input longint pz, input longint t,
                                        inout bit sat);
        longint acc;
        acc = sx(row, 20) * px + sx(row >> 20, 20) * py + sx(row >> 40, 20) * pz;
        return clip(((acc + (64'sd1 <<< 17)) >>> 18) + t, MAX32, sat);
    endfunction

    function automatic longint norm_div(input longint n, input longint d);
        logic [63:0] az;
        logic [63:0] q;
        az = absval(d);
        q = ((absval(n) << QN) + (az >> 1)) / az;
        return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic result_t project(input point_t p);
        result_t r;
        bit      sat;
        longint  xc, yc, zc, u, v, x, y, xd, yd;
        longint  k1, k2, k3, p1, p2, xx, yy, xy, r2, r4, r6, radial, tx, ty;
        sat = 1'b0;
        u = 0;
        v = 0;
        xc = cam_axis(cam_regs[REG_ROT0], p.point_x, p.point_y, p.point_z,
                      sx(cam_regs[REG_TRANS_XY], 32), sat);
        yc = cam_axis(cam_regs[REG_ROT1], p.point_x, p.point_y, p.point_z,
                      sx(cam_regs[REG_TRANS_XY] >> 32, 32), sat);
        zc = cam_axis(cam_regs[REG_ROT2], p.point_x, p.point_y, p.point_z,
                      sx(cam_regs[REG_TRANS_Z], 32), sat);
        if (zc != 0)
        begin
            k1 = sx(cam_regs[REG_DIST], 16);
            k2 = sx(cam_regs[REG_DIST] >> 16, 16);
            p1 = sx(cam_regs[REG_DIST] >> 32, 16);
            p2 = sx(cam_regs[REG_DIST] >> 48, 16);
            k3 = sx(cam_regs[REG_PP_K3] >> 48, 16);
            x = norm_div(xc, zc);
            y = norm_div(yc, zc);
            if (k1 == 0 && k2 == 0 && k3 == 0 && p1 == 0 && p2 == 0)
            begin
                xd = x;
                yd = y;
            end
            else
            begin
                xx = mul_round(x, x, QN, sat);
                yy = mul_round(y, y, QN, sat);
                xy = mul_round(x, y, QN, sat);
                r2 = clip(xx + yy, LIM_I, sat);
                r4 = mul_round(r2, r2, QN, sat);
                r6 = mul_round(r4, r2, QN, sat);
                radial = clip((64'sd1 <<< QN) + mul_round(k1, r2, 12, sat)
                              + mul_round(k2, r4, 12, sat) + mul_round(k3, r6, 12, sat),
                              LIM_I, sat);
                tx = clip(r2 + 2 * xx, LIM_I, sat);
                ty = clip(r2 + 2 * yy, LIM_I, sat);
                xd = clip(mul_round(x, radial, QN, sat) + mul_round(p1, xy, 11, sat)
                          + mul_round(p2, tx, 12, sat), LIM_I, sat);
                yd = clip(mul_round(y, radial, QN, sat) + mul_round(p1, ty, 12, sat)
                          + mul_round(p2, xy, 11, sat), LIM_I, sat);
            end
            u = clip(mul_round(longint'(cam_regs[REG_FOCAL_SKEW][23:0]), xd, QN, sat)
                     + mul_round(sx(cam_regs[REG_FOCAL_SKEW] >> 48, 16), yd, QN, sat)
                     + longint'(cam_regs[REG_PP_K3][23:0]), MAX32, sat);
            v = clip(mul_round(longint'(cam_regs[REG_FOCAL_SKEW][47:24]), yd, QN, sat)
                     + longint'(cam_regs[REG_PP_K3][47:24]), MAX32, sat);
        end
        r.pixel_u = u[31:0];
        r.pixel_v = v[31:0];
        r.camera_depth = zc[31:0];
        r.depth_zero = (zc == 0);
        r.saturated = sat;
        return r;
    endfunction

    task automatic reg_write(input reg_idx_t idx, input logic [63:0] val);
        logic [63:0] masked;
        masked = val;
        if (idx <= REG_ROT2)
            masked = val & 64'h0FFF_FFFF_FFFF_FFFF;
        else if (idx == REG_TRANS_Z)
            masked = val & 64'h0000_0000_FFFF_FFFF;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(8 * int'(idx));
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cam_regs[idx] = masked;
    endtask

    task automatic drain;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60)
            return 0;
        if (k < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_point(input point_t p, input bit with_gaps);
        int g;
        if (with_gaps)
        begin
            g = gap_len();
            if (g > 0)
            begin
                point_valid <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
        point_valid <= 1'b1;
        point <= p;
        @(posedge clk);
        while (point_stall)
            @(posedge clk);
        pending_results.push_back(project(p));
    endtask

    function automatic logic [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 40 << 16)) - (20 <<< 16));
            default: return 32'($urandom_range(1 << 16, 200 << 16));
        endcase
    endfunction

    function automatic logic [59:0] rand_row();
        return 60'({$urandom(), $urandom()});
    endfunction

    task automatic rand_phase(input int n, input bit unbounded);
        point_t p;
        int     i;
        int     mode;
        for (i = 0; i < n; i++)
        begin
            mode = unbounded ? 0 : (($urandom_range(0, 9) < 8) ? 1 : 0);
            p.point_x = rand_coord(mode);
            p.point_y = rand_coord(mode);
            p.point_z = (mode == 1) ? rand_coord(2) : rand_coord(0);
            if ($urandom_range(0, 19) == 0)
                p.point_z = 32'sd0;
            send_point(p, 1'b1);
        end
        point_valid <= 1'b0;
    endtask

    typedef struct {
        point_t  pt;
        bit      known;
        result_t res;
    } dir_row_t;

    dir_row_t    dir_rows [$];

    function automatic dir_row_t mk(input logic [31:0] x, input logic [31:0] y,
                                    input logic [31:0] z);
        dir_row_t d;
        d.pt.point_x = x;
        d.pt.point_y = y;
        d.pt.point_z = z;
        d.known = 1'b0;
        d.res = '0;
        return d;
    endfunction

    initial
    begin
        dir_row_t d;
        int       i;
        errors = 0;
        cycles = 0;
        hold_long = 1'b0;
        rst_n = 1'b0;
        point_valid = 1'b0;
        point = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cam_regs[REG_ROT0] = 64'd262144;
        cam_regs[REG_ROT1] = 64'd274877906944;
        cam_regs[REG_ROT2] = 64'd288230376151711744;
        cam_regs[REG_TRANS_XY] = 64'd0;
        cam_regs[REG_TRANS_Z] = 64'd0;
        cam_regs[REG_FOCAL_SKEW] = 64'd4294967552;
        cam_regs[REG_PP_K3] = 64'd0;
        cam_regs[REG_DIST] = 64'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity camera: zero depth, unit point, extremes
        d = mk(32'd0, 32'd0, 32'd0);
        d.known = 1'b1;
        d.res.depth_zero = 1'b1;
        dir_rows.push_back(d);
        d = mk(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        d.known = 1'b1;
        d.res.pixel_u = 32'sd256;
        d.res.pixel_v = 32'sd256;
        d.res.camera_depth = 32'sh0001_0000;
        dir_rows.push_back(d);
        d = mk(32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
        d.known = 1'b1;
        d.res.depth_zero = 1'b1;
        dir_rows.push_back(d);
        dir_rows.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        dir_rows.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        dir_rows.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001));
        dir_rows.push_back(mk(32'hFFFF_0000, 32'h0003_0000, 32'hFFFE_0000));
        dir_rows.push_back(mk(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF));
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].known)
                pending_results.push_back(dir_rows[i].res);
            else
                pending_results.push_back(project(dir_rows[i].pt));
            point_valid <= 1'b1;
            point <= dir_rows[i].pt;
            @(posedge clk);
            while (point_stall)
                @(posedge clk);
        end
        point_valid <= 1'b0;
        drain();

        // distortion at the extremes, then a mild lens
        reg_write(REG_TRANS_XY, {32'h8000_0000, 32'h7FFF_FFFF});
        reg_write(REG_TRANS_Z, 64'h0000_0000_7FFF_FFFF);
        reg_write(REG_FOCAL_SKEW, 64'hFFFF_FFFF_FFFF_FFFF);
        reg_write(REG_PP_K3, 64'h8000_FFFF_FFFF_FFFF);
        reg_write(REG_DIST, 64'h7FFF_8000_7FFF_8000);
        for (i = 0; i < 6; i++)
        begin
            d = mk(rand_coord(0), rand_coord(0), rand_coord(0));
            send_point(d.pt, 1'b0);
        end
        point_valid <= 1'b0;
        drain();

        reg_write(REG_TRANS_XY, 64'd0);
        reg_write(REG_TRANS_Z, 64'd0);
        reg_write(REG_FOCAL_SKEW, {16'h0040, 24'h01F4_00, 24'h01F4_00});
        reg_write(REG_PP_K3, {16'h0010, 24'h00F0_00, 24'h0140_00});
        reg_write(REG_DIST, {16'hFFF0, 16'h0020, 16'h0100, 16'hFC00});
        for (i = 0; i < 8; i++)
        begin
            d = mk(rand_coord(1), rand_coord(1), rand_coord(2));
            send_point(d.pt, 1'b0);
        end
        point_valid <= 1'b0;
        drain();

        // long receiver hold while points keep coming
        hold_long = 1'b1;
        rand_phase(80, 1'b0);
        drain();
        hold_long = 1'b0;

        for (i = 0; i < 5; i++)
        begin
            reg_write(REG_ROT0, rand_row());
            reg_write(REG_ROT1, rand_row());
            reg_write(REG_ROT2, rand_row());
            reg_write(REG_TRANS_XY, {$urandom(), $urandom()});
            reg_write(REG_TRANS_Z, {32'd0, $urandom()});
            reg_write(REG_FOCAL_SKEW, {$urandom(), $urandom()});
            reg_write(REG_PP_K3, {$urandom(), $urandom()});
            reg_write(REG_DIST, (i == 2) ? 64'd0 : {$urandom(), $urandom()});
            rand_phase(70, i == 4);
            drain();
        end

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        int g;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_long)
            begin
                result_stall <= 1'b1;
                repeat (200) @(posedge clk);
                result_stall <= 1'b0;
                while (hold_long)
                    @(posedge clk);
            end
            g = gap_len();
            if (g > 0)
            begin
                result_stall <= 1'b1;
                repeat (g) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected beat %h", $time, result);
                errors <= errors + 1;
            end
            else
            begin
                e = pending_results.pop_front();
                if (result.pixel_u !== e.pixel_u || result.pixel_v !== e.pixel_v
                    || result.camera_depth !== e.camera_depth
                    || result.depth_zero !== e.depth_zero
                    || result.saturated !== e.saturated)
                begin
                    $display("%0t mismatch expected %h actual %h", $time, e, result);
                    errors <= errors + 1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/ppj_pkg.sv
rtl/core/ppj_delay.sv
rtl/core/ppj_mulsh.sv
rtl/core/ppj_div.sv
rtl/core/ppj_cam.sv
rtl/core/ppj_dist.sv
rtl/core/pinhole_projection_with_distortion.sv
rtl/core/ppj_checker.sv
bench/pinhole_projection_with_distortion_tb.sv
